>>> design/iaf_pkg.sv
package iaf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIG,
    ST_PAD,
    ST_LEAD,
    ST_PRE0,
    ST_PREX,
    ST_SIGN,
    ST_DIGS,
    ST_TRAIL
  } state_e;

  // base_select codes
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // style_flags bit positions
  localparam int unsigned FLAG_LEFT   = 0;
  localparam int unsigned FLAG_SIGN   = 1;
  localparam int unsigned FLAG_SPACE  = 2;
  localparam int unsigned FLAG_ALT    = 3;
  localparam int unsigned FLAG_ZERO   = 4;
  localparam int unsigned FLAG_NOPLUS = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_X     = 8'h78;

  // floor(n / 10) == (n * DEC_RECIP) >> DEC_SHIFT for every 32-bit n
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DEC_SHIFT = 35;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'h0: g = 8'h30;
      4'h1: g = 8'h31;
      4'h2: g = 8'h32;
      4'h3: g = 8'h33;
      4'h4: g = 8'h34;
      4'h5: g = 8'h35;
      4'h6: g = 8'h36;
      4'h7: g = 8'h37;
      4'h8: g = 8'h38;
      4'h9: g = 8'h39;
      4'hA: g = 8'h41;
      4'hB: g = 8'h42;
      4'hC: g = 8'h43;
      4'hD: g = 8'h44;
      4'hE: g = 8'h45;
      default: g = 8'h46;
    endcase
    return g;
  endfunction

endpackage

>>> design/integer_ascii_formatter.sv
// Formats one 32-bit value as printf-style ASCII text (octal, decimal or upper-case hex, with
// sign, space, alternate-prefix, zero-fill, left-align and no-plus flags) and streams it out
// one character per item, tlast on the final one. Digits come from one shared divide-by-radix
// unit: octal and hex digits come straight from shifts, decimal digits from a registered 32x32
// reciprocal multiply followed by quotient and remainder, least significant first into a small
// digit store. A sizing state then works out the fill, and one character leaves per cycle while
// the output is taken. s_axis_tready_o is low from acceptance until the last character is
// registered.
module integer_ascii_formatter #(
  parameter int unsigned MAX_WIDTH   = 64,
  parameter int unsigned DIGIT_SLOTS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] value, [38:32] pad_width, [39] zero
  input  logic [7:0]  s_axis_tuser_i,  // [1:0] base_select, [7:2] style_flags
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_char
  output logic        m_axis_tlast_o   // last_char
);
  import iaf_pkg::*;

  localparam int unsigned CNTW = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned IW   = $clog2(DIGIT_SLOTS);
  localparam int unsigned PW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW   = (PW > 7) ? PW : 7;

  state_e           state_q, state_d;
  logic [31:0]      num_q, num_d;
  logic [63:0]      prod_q, prod_d;
  logic [1:0]       bsel_q, bsel_d;
  logic [5:0]       flags_q, flags_d;
  logic [PW-1:0]    w_q, w_d;
  logic             has_sign_q, has_sign_d;
  logic [7:0]       sign_ch_q, sign_ch_d;
  logic [CNTW-1:0]  dcnt_q, dcnt_d;
  logic [PW-1:0]    pad_q, pad_d;
  logic             m_valid_q, m_valid_d;
  logic [7:0]       m_data_q, m_data_d;
  logic             m_last_q, m_last_d;
  logic [3:0]       store_q [DIGIT_SLOTS];
  logic             st_we;
  logic [3:0]       st_wdata;

  logic             in_fire;
  logic             slot_free;
  logic             is_dec;
  logic [1:0]       prefix_len;
  state_e           route;
  logic [31:0]      quot;
  logic [31:0]      q_times_r;
  logic [3:0]       rem;
  logic [CW-1:0]    w_in;
  logic [CW-1:0]    text_len;
  logic [CW-1:0]    w_ext;
  logic [CNTW-1:0]  dcnt_m1;
  logic [31:0]      val_in;
  logic [1:0]       bsel_in;
  logic [5:0]       flags_in;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  assign val_in   = s_axis_tdata_i[31:0];
  assign bsel_in  = s_axis_tuser_i[1:0];
  assign flags_in = s_axis_tuser_i[7:2];
  assign w_in     = CW'(s_axis_tdata_i[38:32]);

  assign is_dec  = (bsel_q == BASE_DEC);
  assign dcnt_m1 = dcnt_q - CNTW'(1);

  always_comb begin
    prefix_len = 2'd0;
    if (flags_q[FLAG_ALT]) begin
      if (bsel_q == BASE_OCT) begin
        prefix_len = 2'd1;
      end else if (bsel_q != BASE_DEC) begin
        prefix_len = 2'd2;
      end
    end
  end

  // text after the lead fill
  always_comb begin
    if (prefix_len != 2'd0) begin
      route = ST_PRE0;
    end else if (has_sign_q) begin
      route = ST_SIGN;
    end else begin
      route = ST_DIGS;
    end
  end

  // shared divide-by-radix unit
  always_comb begin
    unique case (bsel_q)
      BASE_OCT: quot = {3'b000, num_q[31:3]};
      BASE_DEC: quot = {3'b000, prod_q[63:DEC_SHIFT]};
      default:  quot = {4'b0000, num_q[31:4]};
    endcase
    q_times_r = (quot << 3) + (quot << 1);
    unique case (bsel_q)
      BASE_OCT: rem = {1'b0, num_q[2:0]};
      BASE_DEC: rem = 4'(num_q - q_times_r);
      default:  rem = num_q[3:0];
    endcase
  end

  assign w_ext    = CW'(w_q);
  assign text_len = CW'(prefix_len) + CW'(has_sign_q) + CW'(dcnt_q);

  always_comb begin
    state_d    = state_q;
    num_d      = num_q;
    prod_d     = prod_q;
    bsel_d     = bsel_q;
    flags_d    = flags_q;
    w_d        = w_q;
    has_sign_d = has_sign_q;
    sign_ch_d  = sign_ch_q;
    dcnt_d     = dcnt_q;
    pad_d      = pad_q;
    st_we      = 1'b0;
    st_wdata   = rem;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          bsel_d     = bsel_in;
          flags_d    = flags_in;
          w_d        = (w_in > CW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(w_in);
          dcnt_d     = '0;
          num_d      = val_in;
          has_sign_d = 1'b0;
          sign_ch_d  = CH_SPACE;
          if (bsel_in == BASE_DEC) begin
            if (flags_in[FLAG_SIGN]) begin
              if (val_in[31]) begin
                has_sign_d = 1'b1;
                sign_ch_d  = CH_MINUS;
                num_d      = 32'd0 - val_in;
              end else if (!flags_in[FLAG_NOPLUS]) begin
                has_sign_d = 1'b1;
                sign_ch_d  = CH_PLUS;
              end else if (flags_in[FLAG_SPACE]) begin
                has_sign_d = 1'b1;
              end
            end else if (!val_in[31] && flags_in[FLAG_SPACE]) begin
              has_sign_d = 1'b1;
            end
            state_d = ST_MUL;
          end else begin
            state_d = ST_DIG;
          end
        end
      end
      ST_MUL: begin
        prod_d  = num_q * DEC_RECIP;
        state_d = ST_DIG;
      end
      ST_DIG: begin
        st_we  = 1'b1;
        num_d  = quot;
        dcnt_d = dcnt_q + CNTW'(1);
        if (quot != 32'd0 && (dcnt_q + CNTW'(1)) < CNTW'(DIGIT_SLOTS)) begin
          state_d = is_dec ? ST_MUL : ST_DIG;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        pad_d = (w_ext > text_len) ? PW'(w_ext - text_len) : '0;
        if (!flags_q[FLAG_LEFT] && w_ext > text_len) begin
          state_d = ST_LEAD;
        end else begin
          state_d = route;
        end
      end
      ST_LEAD: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = flags_q[FLAG_ZERO] ? CH_ZERO : CH_SPACE;
          m_last_d  = 1'b0;
          pad_d     = pad_q - PW'(1);
          if (pad_q == PW'(1)) begin
            state_d = route;
          end
        end
      end
      ST_PRE0: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = CH_ZERO;
          m_last_d  = 1'b0;
          if (prefix_len == 2'd2) begin
            state_d = ST_PREX;
          end else begin
            state_d = has_sign_q ? ST_SIGN : ST_DIGS;
          end
        end
      end
      ST_PREX: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = CH_X;
          m_last_d  = 1'b0;
          state_d   = has_sign_q ? ST_SIGN : ST_DIGS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = sign_ch_q;
          m_last_d  = 1'b0;
          state_d   = ST_DIGS;
        end
      end
      ST_DIGS: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = digit_glyph(store_q[dcnt_m1[IW-1:0]]);
          m_last_d  = (dcnt_q == CNTW'(1)) && (pad_q == '0);
          dcnt_d    = dcnt_m1;
          if (dcnt_q == CNTW'(1)) begin
            state_d = (pad_q == '0) ? ST_IDLE : ST_TRAIL;
          end
        end
      end
      ST_TRAIL: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = CH_SPACE;
          m_last_d  = (pad_q == PW'(1));
          pad_d     = pad_q - PW'(1);
          if (pad_q == PW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dcnt_q    <= '0;
      pad_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dcnt_q    <= dcnt_d;
      pad_q     <= pad_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q      <= num_d;
    prod_q     <= prod_d;
    bsel_q     <= bsel_d;
    flags_q    <= flags_d;
    w_q        <= w_d;
    has_sign_q <= has_sign_d;
    sign_ch_q  <= sign_ch_d;
    m_data_q   <= m_data_d;
    m_last_q   <= m_last_d;
    if (st_we) begin
      store_q[dcnt_q[IW-1:0]] <= st_wdata;
    end
  end

  a_dcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= CNTW'(DIGIT_SLOTS))
    else $error("digit count beyond store depth");

  a_pad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q <= PW'(MAX_WIDTH))
    else $error("fill count beyond maximum width");

  a_digs_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGS) |-> (dcnt_q != '0))
    else $error("digit emission with empty store");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE) && !s_axis_tready_o)
    else $error("item accepted but sequencer stayed idle");

  a_trail_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRAIL && pad_q == PW'(1) && slot_free)
      |=> (state_q == ST_IDLE) && m_axis_tlast_o && m_axis_tvalid_o)
    else $error("final fill character not marked last");

endmodule
